>>> design/two_stack_queue_assert.svh
// assertion macros for the two stack queue
`ifndef TWO_STACK_QUEUE_ASSERT_SVH
`define TWO_STACK_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
// implication checked on every rising edge outside reset
`define TSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen on a rising edge
`define TSQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TSQ_ASSERT(lbl, prop, msg)
`define TSQ_NEVER(lbl, cond, msg)
`endif

`endif

>>> design/tsq_pkg.sv
package tsq_pkg;

	localparam int WORD_W    = 32;
	localparam int IDX_W     = 5;
	localparam int COUNT_W   = 6;
	localparam int CFG_W     = 5;
	localparam int READ_SPAN = 2 ** IDX_W;

	localparam logic [CFG_W-1:0] DEPTH_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_READ   = 2'd2,
		OP_STATUS = 2'd3
	} op_t;

	// per-cycle control broadcast along the cell row
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

>>> design/tsq_cell.sv
module tsq_cell #(
	parameter int IDX   = 0,
	parameter int POS_W = 6
) (
	input  logic                        clk,
	input  tsq_pkg::cell_ctl_t          ctl,
	input  logic [POS_W-1:0]            wr_pos,
	input  logic [tsq_pkg::WORD_W-1:0]  push_word,
	input  logic [tsq_pkg::WORD_W-1:0]  nbr_word,
	output logic [tsq_pkg::WORD_W-1:0]  word
);

	logic [tsq_pkg::WORD_W-1:0] word_q;
	logic                       hit;

	// this cell is the first free slot
	assign hit = (wr_pos == POS_W'(IDX));

	// pop moves every word one cell towards the head, push fills the free slot
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			word_q <= nbr_word;
		end else if (ctl.push && hit) begin
			word_q <= push_word;
		end
	end

	assign word = word_q;

endmodule

>>> design/tsq_chain.sv
module tsq_chain #(
	parameter int NCELLS = 32,
	parameter int POS_W  = 6
) (
	input  logic                        clk,
	input  tsq_pkg::cell_ctl_t          ctl,
	input  logic [POS_W-1:0]            wr_pos,
	input  logic [tsq_pkg::WORD_W-1:0]  push_word,
	input  logic [tsq_pkg::IDX_W-1:0]   read_index,
	output logic [tsq_pkg::WORD_W-1:0]  head_word,
	output logic [tsq_pkg::WORD_W-1:0]  rd_word
);

	localparam int RD_N = (NCELLS < tsq_pkg::READ_SPAN) ? NCELLS : tsq_pkg::READ_SPAN;

	logic [tsq_pkg::WORD_W-1:0] cell_word [NCELLS];

	// row of cells, cell zero holds the oldest word
	for (genvar k = 0; k < NCELLS; k++) begin : g_cell
		logic [tsq_pkg::WORD_W-1:0] nbr;
		if (k == NCELLS - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_word[k+1];
		end
		tsq_cell #(
			.IDX   (k),
			.POS_W (POS_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr_pos    (wr_pos),
			.push_word (push_word),
			.nbr_word  (nbr),
			.word      (cell_word[k])
		);
	end

	assign head_word = cell_word[0];

	// indexed read over the cells the index can reach
	always_comb begin
		rd_word = '0;
		for (int k = 0; k < RD_N; k++) begin
			if (read_index == tsq_pkg::IDX_W'(k)) begin
				rd_word = cell_word[k];
			end
		end
	end

endmodule

>>> design/two_stack_queue.sv
// FIFO of signed 32-bit words that behaves as an input stack and an output stack of
// stack_depth words each (clamped to 1..STACK_DEPTH). The words are kept in arrival
// order in a row of 2*STACK_DEPTH cells, with the split between the two stacks held
// only as two counts, so a move between the stacks costs nothing and a pop shifts the
// whole row one cell towards the head. An item is
// taken on each cycle in which the output register is free or being emptied, and its
// result appears in the output register on the next cycle. Push, pop, indexed read and
// status query each give one result with data, error, count and is_full. No clearing
// is needed after reset; cells never written read as undefined data. Write stack_depth
// only while no item is in flight.
`include "two_stack_queue_assert.svh"

module two_stack_queue #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                stack_depth_we,
	input  logic [tsq_pkg::CFG_W-1:0]           stack_depth,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic signed [tsq_pkg::WORD_W-1:0]   push_value,
	input  logic [tsq_pkg::IDX_W-1:0]           read_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tsq_pkg::WORD_W-1:0]   data,
	output logic                                error,
	output logic [tsq_pkg::COUNT_W-1:0]         count,
	output logic                                is_full
);

	localparam int NCELLS = 2 * STACK_DEPTH;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int POS_W  = $clog2(NCELLS + 1);

	logic [tsq_pkg::CFG_W-1:0]  depth_q;
	logic [CNT_W-1:0]           in_cnt_q;
	logic [CNT_W-1:0]           out_cnt_q;
	logic [CNT_W-1:0]           in_cnt_n;
	logic [CNT_W-1:0]           out_cnt_n;
	logic [CNT_W-1:0]           eff_depth;
	logic [POS_W-1:0]           total;
	logic [POS_W-1:0]           total_n;
	logic [POS_W+tsq_pkg::COUNT_W-1:0] total_ext;
	logic                       in_fire;
	logic                       in_full;
	logic                       push_block;
	logic                       res_err;
	logic [tsq_pkg::WORD_W-1:0] res_data;
	tsq_pkg::op_t               op;
	tsq_pkg::cell_ctl_t         ctl;
	logic [tsq_pkg::WORD_W-1:0] head_word;
	logic [tsq_pkg::WORD_W-1:0] rd_word;

	logic                       out_valid_q;
	logic signed [tsq_pkg::WORD_W-1:0] data_q;
	logic                       error_q;
	logic [tsq_pkg::COUNT_W-1:0] count_q;
	logic                       is_full_q;

	assign op       = tsq_pkg::op_t'(operation);
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	// configured depth, clamped to 1..STACK_DEPTH
	always_comb begin
		if (depth_q == '0) begin
			eff_depth = CNT_W'(1);
		end else if (32'(depth_q) > STACK_DEPTH) begin
			eff_depth = CNT_W'(STACK_DEPTH);
		end else begin
			eff_depth = CNT_W'(depth_q);
		end
	end

	assign total      = POS_W'(in_cnt_q) + POS_W'(out_cnt_q);
	assign in_full    = (in_cnt_q >= eff_depth);
	assign push_block = in_full && (out_cnt_q != '0);

	// next counts, cell control and result for the offered item
	always_comb begin
		in_cnt_n  = in_cnt_q;
		out_cnt_n = out_cnt_q;
		ctl       = '0;
		res_err   = 1'b0;
		res_data  = '0;
		case (op)
			tsq_pkg::OP_PUSH: begin
				if (push_block) begin
					res_err = 1'b1;
				end else begin
					ctl.push = 1'b1;
					if (in_full) begin
						out_cnt_n = in_cnt_q;
						in_cnt_n  = CNT_W'(1);
					end else begin
						in_cnt_n = in_cnt_q + CNT_W'(1);
					end
				end
			end
			tsq_pkg::OP_POP: begin
				if (out_cnt_q != '0) begin
					ctl.pop   = 1'b1;
					out_cnt_n = out_cnt_q - CNT_W'(1);
					res_data  = head_word;
				end else if (in_cnt_q != '0) begin
					ctl.pop  = 1'b1;
					in_cnt_n = in_cnt_q - CNT_W'(1);
					res_data = head_word;
				end else begin
					res_err = 1'b1;
				end
			end
			tsq_pkg::OP_READ: begin
				if (32'(read_index) >= 32'(total)) begin
					res_err = 1'b1;
				end else begin
					res_data = rd_word;
				end
			end
			tsq_pkg::OP_STATUS: begin
			end
			default: begin
			end
		endcase
		ctl.push = ctl.push && in_fire;
		ctl.pop  = ctl.pop && in_fire;
	end

	assign total_n   = POS_W'(in_cnt_n) + POS_W'(out_cnt_n);
	assign total_ext = (POS_W + tsq_pkg::COUNT_W)'(total_n);

	tsq_chain #(
		.NCELLS (NCELLS),
		.POS_W  (POS_W)
	) u_chain (
		.clk        (clk),
		.ctl        (ctl),
		.wr_pos     (total),
		.push_word  (push_value),
		.read_index (read_index),
		.head_word  (head_word),
		.rd_word    (rd_word)
	);

	// configuration and stack counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= tsq_pkg::DEPTH_RESET;
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (stack_depth_we) begin
				depth_q <= stack_depth;
			end
			if (in_fire) begin
				in_cnt_q  <= in_cnt_n;
				out_cnt_q <= out_cnt_n;
			end
		end
	end

	// output register, loaded on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q    <= res_data;
			error_q   <= res_err;
			count_q   <= total_ext[tsq_pkg::COUNT_W-1:0];
			is_full_q <= (in_cnt_n >= eff_depth) && (out_cnt_n != '0);
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign error     = error_q;
	assign count     = count_q;
	assign is_full   = is_full_q;

	// checks on counts and results
	`TSQ_ASSERT(a_fire_gives_result, in_fire |=> out_valid_q, "accepted item gave no result")
	`TSQ_ASSERT(a_pop_empty_err,
		(in_fire && op == tsq_pkg::OP_POP && total == '0) |=> (error_q && data_q == '0),
		"pop of empty queue not flagged")
	`TSQ_ASSERT(a_pop_count,
		(in_fire && op == tsq_pkg::OP_POP && total != '0) |=> (total == $past(total) - 1'b1),
		"pop did not remove one word")
	`TSQ_ASSERT(a_push_count,
		(in_fire && op == tsq_pkg::OP_PUSH && !push_block) |=> (total == $past(total) + 1'b1),
		"push did not add one word")
	`TSQ_NEVER(a_stack_bound, (in_cnt_q > STACK_DEPTH) || (out_cnt_q > STACK_DEPTH),
		"stack count beyond stack size")

endmodule
